// ===== hdl/chte_pkg.sv =====
// chte_pkg: shared types and constants for the chained hash table engine
// no dependencies
package chte_pkg;

	localparam int ENTRIES_DEF   = 256;
	localparam int DATA_BITS_DEF = 64;
	localparam int NBUCKETS      = 256;
	localparam int BKT_W         = 8;
	localparam int CFG_W         = 9;
	localparam int KEY_W         = 64;

	localparam logic [1:0] ACT_ADD    = 2'd0;
	localparam logic [1:0] ACT_REMOVE = 2'd1;
	localparam logic [1:0] ACT_SEARCH = 2'd2;

	localparam logic [1:0] ST_MISS    = 2'd0;
	localparam logic [1:0] ST_OK      = 2'd1;
	localparam logic [1:0] ST_REPLACE = 2'd2;

	localparam logic CFG_BUCKETS = 1'b0;
	localparam logic CFG_DUPS    = 1'b1;

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_MOD, S_HEAD, S_WALK, S_CMP, S_UPD1, S_UPD2, S_UPD3, S_OUT
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load;      // capture request
		logic init_step; // clear one head / link one free entry
		logic mod_step;  // one bit of key modulo
		logic rd_head;   // read bucket head
		logic rd_entry;  // read entry at cur
		logic advance;   // prev <= cur, cur <= link
		logic upd1;
		logic upd2;
		logic set_result;
	} cmd_t;

	typedef struct packed {
		logic init_done;
		logic mod_done;
		logic cur_none;
		logic key_match;
		logic steps_done;
	} sts_t;

endpackage

// ===== hdl/chained_hash_table_engine_unit.sv =====
// chained_hash_table_engine_unit: top level of the chained hash table engine
// depends on chte_pkg, chte_ctrl, chte_dp
//
// one request word in (action, key, value) gives one result word out
// (status, old_value). both channels use valid/stall; a word moves on a
// clock edge where valid is high and stall low.
// the unit handles one request at a time: in_stall is low only when idle.
// after the request is taken: a bit-serial key modulo, one key bit per
// step, then a finishing step, one head read, a read and a compare per
// chain entry, one more walk step when the walk ends without a match,
// and three update steps; the result is then valid in the output
// register. the result holds in the output register while out_stall is
// high; the next request is taken once it has gone.
// after reset a clearing pass empties the bucket heads and links the
// free list in index order; no request is taken during it.
// configuration is to be written only while no request is in flight;
// the user must keep to this, the block itself does not enforce it.
// configuration: cfg_we with cfg_index 0 bucket_count, 1 allow_duplicates.
module chained_hash_table_engine_unit #(
	parameter int ENTRIES   = chte_pkg::ENTRIES_DEF,
	parameter int DATA_BITS = chte_pkg::DATA_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [8:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [63:0] key,
	input  logic [63:0] value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [63:0] old_value
);

	chte_pkg::cmd_t cmd;
	chte_pkg::sts_t sts;

	// sequencing
	chte_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall),
		.cmd(cmd), .sts(sts)
	);

	// tables and walk
	chte_dp #(.ENTRIES(ENTRIES), .DATA_BITS(DATA_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.action(action), .key(key), .value(value),
		.status(status), .old_value(old_value),
		.cmd(cmd), .sts(sts)
	);

endmodule

// ===== hdl/chte_ctrl.sv =====
// chte_ctrl: sequencing state machine for the hash engine
// depends on chte_pkg
module chte_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	output chte_pkg::cmd_t     cmd,
	input  chte_pkg::sts_t     sts
);

	chte_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= chte_pkg::S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_stall = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			chte_pkg::S_INIT: begin
				cmd.init_step = 1'b1;
				if (sts.init_done) state_d = chte_pkg::S_IDLE;
			end
			chte_pkg::S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = chte_pkg::S_MOD;
				end
			end
			chte_pkg::S_MOD: begin
				if (sts.mod_done) state_d = chte_pkg::S_HEAD;
				else cmd.mod_step = 1'b1;
			end
			chte_pkg::S_HEAD: begin
				cmd.rd_head = 1'b1;
				state_d = chte_pkg::S_WALK;
			end
			chte_pkg::S_WALK: begin
				if (sts.cur_none || sts.steps_done) begin
					state_d = chte_pkg::S_UPD1;
				end else begin
					cmd.rd_entry = 1'b1;
					state_d = chte_pkg::S_CMP;
				end
			end
			chte_pkg::S_CMP: begin
				if (sts.key_match) begin
					state_d = chte_pkg::S_UPD1;
				end else begin
					cmd.advance = 1'b1;
					state_d = chte_pkg::S_WALK;
				end
			end
			chte_pkg::S_UPD1: begin
				cmd.upd1 = 1'b1;
				state_d = chte_pkg::S_UPD2;
			end
			chte_pkg::S_UPD2: begin
				cmd.upd2 = 1'b1;
				state_d = chte_pkg::S_UPD3;
			end
			chte_pkg::S_UPD3: begin
				cmd.set_result = 1'b1;
				state_d = chte_pkg::S_OUT;
			end
			chte_pkg::S_OUT: begin
				out_valid = 1'b1;
				if (!out_stall) state_d = chte_pkg::S_IDLE;
			end
			default: state_d = chte_pkg::S_IDLE;
		endcase
	end

endmodule

// ===== hdl/chte_dp.sv =====
// chte_dp: tables, bucket modulo and chain walk datapath
// depends on chte_pkg
module chte_dp #(
	parameter int ENTRIES   = chte_pkg::ENTRIES_DEF,
	parameter int DATA_BITS = chte_pkg::DATA_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic                     cfg_index,
	input  logic [chte_pkg::CFG_W-1:0] cfg_data,
	input  logic [1:0]               action,
	input  logic [chte_pkg::KEY_W-1:0] key,
	input  logic [63:0]              value,
	output logic [1:0]               status,
	output logic [63:0]              old_value,
	input  chte_pkg::cmd_t           cmd,
	output chte_pkg::sts_t           sts
);

	localparam int IW = $clog2(ENTRIES + 1);
	localparam int AW = $clog2(ENTRIES);
	localparam logic [IW-1:0] NONE = IW'(ENTRIES);
	localparam int KW = chte_pkg::KEY_W;
	localparam int BW = chte_pkg::BKT_W;
	// clearing pass covers both the bucket heads and the entry links
	localparam int INIT_N = (ENTRIES > chte_pkg::NBUCKETS) ? ENTRIES : chte_pkg::NBUCKETS;
	localparam int CW = $clog2(INIT_N + 1);

	logic [chte_pkg::CFG_W-1:0] bcount_q;
	logic                       dups_q;

	logic [KW-1:0]        key_mem [ENTRIES];
	logic [DATA_BITS-1:0] val_mem [ENTRIES];
	logic [IW-1:0]        link_mem [ENTRIES];
	logic [IW-1:0]        head_mem [chte_pkg::NBUCKETS];

	logic [1:0]           act_q;
	logic [KW-1:0]        key_q;
	logic [DATA_BITS-1:0] val_q;
	logic [8:0]           modn_q;
	logic [KW-1:0]        kshift_q;
	logic [8:0]           rem_q;
	logic [6:0]           mcnt_q;
	logic [BW-1:0]        bkt_q;
	logic [IW-1:0]        cur_q, prev_q, link_q, head_q, free_q, e_q;
	logic [KW-1:0]        rkey_q;
	logic [DATA_BITS-1:0] rval_q;
	logic                 found_q;
	logic [IW:0]          steps_q;
	logic [CW-1:0]        init_q;
	logic [1:0]           status_q;
	logic [63:0]          old_q;

	logic [9:0] rem_sh;
	logic [9:0] rem_sub;
	logic       fnd;

	always_comb begin
		rem_sh  = {rem_q, kshift_q[KW-1]};
		rem_sub = rem_sh - {1'b0, modn_q};
	end

	assign sts.init_done  = (init_q == CW'(INIT_N));
	assign sts.mod_done   = (mcnt_q == 7'(KW));
	assign sts.cur_none   = (cur_q >= NONE);
	assign sts.key_match  = (rkey_q == key_q);
	assign sts.steps_done = (steps_q >= (IW+1)'(ENTRIES));

	// the walk stopped on a match when cur is live, the step limit is not reached and the read key matches
	assign fnd = !sts.cur_none && !sts.steps_done && (rkey_q == key_q)
		&& (act_q != chte_pkg::ACT_ADD || !dups_q);

	assign status    = status_q;
	assign old_value = old_q;

	// configuration and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcount_q <= chte_pkg::CFG_W'(256);
			dups_q   <= 1'b0;
			init_q   <= '0;
			free_q   <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == chte_pkg::CFG_BUCKETS) bcount_q <= cfg_data;
				else dups_q <= cfg_data[0];
			end
			if (cmd.init_step && init_q != CW'(INIT_N)) init_q <= init_q + 1'b1;
			// new entry taken off the free list
			if (cmd.upd2 && act_q == chte_pkg::ACT_ADD && !found_q && e_q < NONE)
				free_q <= link_q;
			// removed entry pushed onto the free list
			if (cmd.upd2 && act_q == chte_pkg::ACT_REMOVE && found_q)
				free_q <= e_q;
		end
	end

	// memories and walk registers
	always_ff @(posedge clk) begin
		if (cmd.init_step) begin
			if (init_q < CW'(chte_pkg::NBUCKETS)) head_mem[init_q[BW-1:0]] <= NONE;
			if (init_q < CW'(ENTRIES)) link_mem[init_q[AW-1:0]] <= IW'(init_q + 1'b1);
		end
		if (cmd.load) begin
			act_q    <= action;
			key_q    <= key;
			val_q    <= value[DATA_BITS-1:0];
			kshift_q <= key;
			rem_q    <= '0;
			mcnt_q   <= '0;
			found_q  <= 1'b0;
			steps_q  <= '0;
			prev_q   <= NONE;
			if (bcount_q == '0) modn_q <= 9'd1;
			else if (bcount_q > 9'd256) modn_q <= 9'd256;
			else modn_q <= bcount_q;
		end
		if (cmd.mod_step) begin
			kshift_q <= kshift_q << 1;
			mcnt_q   <= mcnt_q + 1'b1;
			rem_q    <= rem_sub[9] ? rem_sh[8:0] : rem_sub[8:0];
		end
		if (cmd.rd_head) begin
			bkt_q  <= rem_q[BW-1:0];
			cur_q  <= head_mem[rem_q[BW-1:0]];
			head_q <= head_mem[rem_q[BW-1:0]];
			// an add with duplicates allowed skips the search
			if (act_q == chte_pkg::ACT_ADD && dups_q) cur_q <= NONE;
		end
		if (cmd.rd_entry) begin
			rkey_q <= key_mem[cur_q[AW-1:0]];
			rval_q <= val_mem[cur_q[AW-1:0]];
			link_q <= link_mem[cur_q[AW-1:0]];
		end
		if (cmd.advance) begin
			prev_q  <= cur_q;
			cur_q   <= link_q;
			steps_q <= steps_q + 1'b1;
		end
		if (cmd.upd1) begin
			e_q <= cur_q;
			if (fnd) begin
				found_q <= 1'b1;
				if (act_q == chte_pkg::ACT_ADD) begin
					val_mem[cur_q[AW-1:0]] <= val_q;
					if (prev_q < NONE) link_mem[prev_q[AW-1:0]] <= link_q;
				end else if (act_q == chte_pkg::ACT_REMOVE) begin
					if (prev_q < NONE) link_mem[prev_q[AW-1:0]] <= link_q;
					else head_mem[bkt_q] <= link_q;
				end
			end else if (act_q == chte_pkg::ACT_ADD) begin
				// free head, none when the pool is empty
				e_q <= free_q;
				link_q <= link_mem[free_q[AW-1:0]];
			end
		end
		if (cmd.upd2) begin
			if (act_q == chte_pkg::ACT_ADD) begin
				if (found_q) begin
					if (prev_q < NONE) begin
						link_mem[e_q[AW-1:0]] <= head_q;
						head_mem[bkt_q] <= e_q;
					end
				end else if (e_q < NONE) begin
					key_mem[e_q[AW-1:0]]  <= key_q;
					val_mem[e_q[AW-1:0]]  <= val_q;
					link_mem[e_q[AW-1:0]] <= head_q;
					head_mem[bkt_q]       <= e_q;
				end
			end else if (act_q == chte_pkg::ACT_REMOVE && found_q) begin
				link_mem[e_q[AW-1:0]] <= free_q;
			end
		end
		if (cmd.set_result) begin
			status_q <= chte_pkg::ST_MISS;
			old_q    <= '0;
			if (act_q == chte_pkg::ACT_ADD) begin
				if (found_q) begin
					status_q <= chte_pkg::ST_REPLACE;
					old_q    <= 64'(rval_q);
				end else if (e_q < NONE) begin
					status_q <= chte_pkg::ST_OK;
				end
			end else if ((act_q == chte_pkg::ACT_REMOVE || act_q == chte_pkg::ACT_SEARCH)
				&& found_q) begin
				status_q <= chte_pkg::ST_OK;
				old_q    <= 64'(rval_q);
			end
		end
	end

endmodule

// ===== hdl/chte_checker.sv =====
// chte_checker: port-level checks for the chained hash table engine
// depends on chte_pkg and the top level
module chte_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  status,
	input logic [63:0] old_value
);

	// one request at a time
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input open while result pending");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall) else $error("second word taken");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(old_value))
		else $error("result dropped");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == chte_pkg::ST_MISS || status == chte_pkg::ST_OK
		|| status == chte_pkg::ST_REPLACE)) else $error("bad status");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == chte_pkg::ST_MISS |-> old_value == '0)
		else $error("miss with data");

endmodule

bind chained_hash_table_engine_unit chte_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall),
	.status(status), .old_value(old_value)
);
